// File: hdl/epc_pkg.sv
// Shared widths, command codes and controller/datapath interface types.
package epc_pkg;

   localparam int OP_W       = 4;
   localparam int PORT_W     = 3;
   localparam int SP_W       = 16;
   localparam int TIME_W     = 32;
   localparam int PULSE_W    = 16;
   localparam int SCALE_W    = 23;
   localparam int MODE_W     = 2;
   localparam int STAT_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int QUO_W      = 32;
   localparam int TICK_MAX   = 8;

   // command codes
   localparam logic [OP_W-1:0] OP_SET10       = 4'd0;
   localparam logic [OP_W-1:0] OP_SET12       = 4'd1;
   localparam logic [OP_W-1:0] OP_SET16       = 4'd2;
   localparam logic [OP_W-1:0] OP_ARM         = 4'd3;
   localparam logic [OP_W-1:0] OP_DISARM      = 4'd4;
   localparam logic [OP_W-1:0] OP_START       = 4'd5;
   localparam logic [OP_W-1:0] OP_STOP        = 4'd6;
   localparam logic [OP_W-1:0] OP_GET_STATE   = 4'd7;
   localparam logic [OP_W-1:0] OP_TICK        = 4'd8;
   localparam logic [OP_W-1:0] OP_ACK_NACK    = 4'd9;
   localparam logic [OP_W-1:0] OP_UNSUPPORTED = 4'd10;

   // port modes
   localparam logic [MODE_W-1:0] MODE_DISARMED = 2'd0;
   localparam logic [MODE_W-1:0] MODE_STOPPED  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RUNNING  = 2'd2;

   // result status
   localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
   localparam logic [STAT_W-1:0] ST_ACK    = 2'd1;
   localparam logic [STAT_W-1:0] ST_REJECT = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PULSE_ARM      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PULSE_START    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PULSE_MIN      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PULSE_MAX      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SETPOINT_SCALE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT_US     = 3'd5;

   typedef struct packed {
      logic load_req;
      logic load_prod;
      logic div_start;
      logic write_port;
      logic tick_load;
      logic tick_check;
      logic tick_next;
      logic emit_port;
      logic emit_tick;
   } epc_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            port_ok;
      logic            div_done;
      logic            tick_last;
   } epc_stat_type;

endpackage

// File: hdl/epc_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
module epc_divider
   import epc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [QUO_W-1:0]   dividend,
   input  logic [SCALE_W-1:0] divisor,
   output logic               done,
   output logic [QUO_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(QUO_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SCALE_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [SCALE_W-1:0] dvs_ff, dvs_in;
   logic [SCALE_W:0]   shifted;
   logic [SCALE_W:0]   diff;
   logic               fits;

   assign shifted = {rem_ff, quo_ff[QUO_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QUO_W - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[SCALE_W-1:0] : shifted[SCALE_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_no_restart : assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

endmodule

// File: hdl/epc_datapath.sv
// Port state stores, setpoint scaling, tick walk and result register.
module epc_datapath
   import epc_pkg::*;
#(
   parameter int PORTS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  epc_cmd_type           cmd,
   output epc_stat_type          stat,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [PORT_W-1:0]     req_port,
   input  logic [SP_W-1:0]       req_setpoint,
   input  logic [TIME_W-1:0]     req_now_us,
   output logic [PORT_W-1:0]     rsp_out_port,
   output logic [PULSE_W-1:0]    rsp_pulse_compare,
   output logic [MODE_W-1:0]     rsp_port_mode,
   output logic [STAT_W-1:0]     rsp_status,
   output logic                  rsp_reply_valid,
   output logic                  rsp_last,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W  = (PORTS > 1) ? $clog2(PORTS) : 1;
   localparam int TICK_N = (PORTS < TICK_MAX) ? PORTS : TICK_MAX;
   localparam int CNT_W  = (TICK_N > 1) ? $clog2(TICK_N) : 1;
   localparam int PROD_W = 2 * (PULSE_W + 1);
   localparam int X_W    = QUO_W + 2;

   // configuration
   logic [PULSE_W-1:0] arm_ff, start_ff, min_ff, max_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic [TIME_W-1:0]  timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_ff     <= '0;
         start_ff   <= '0;
         min_ff     <= '0;
         max_ff     <= '1;
         scale_ff   <= SCALE_W'(65536);
         timeout_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PULSE_ARM:      arm_ff     <= csr_wdata[PULSE_W-1:0];
            REG_PULSE_START:    start_ff   <= csr_wdata[PULSE_W-1:0];
            REG_PULSE_MIN:      min_ff     <= csr_wdata[PULSE_W-1:0];
            REG_PULSE_MAX:      max_ff     <= csr_wdata[PULSE_W-1:0];
            REG_SETPOINT_SCALE: scale_ff   <= csr_wdata[SCALE_W-1:0];
            REG_TIMEOUT_US:     timeout_ff <= csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // latched request word
   logic [OP_W-1:0]   op_ff;
   logic [PORT_W-1:0] port_ff;
   logic [SP_W-1:0]   sp_ff;
   logic [TIME_W-1:0] now_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= req_operation;
         port_ff <= req_port;
         sp_ff   <= req_setpoint;
         now_ff  <= req_now_us;
      end
   end

   logic             port_ok;
   logic [IDX_W-1:0] sel_idx;
   logic [IDX_W-1:0] rd_idx;
   logic             is_tick;

   assign port_ok = 32'(port_ff) < 32'(PORTS);
   assign sel_idx = port_ok ? IDX_W'(port_ff) : '0;
   assign is_tick = op_ff == OP_TICK;

   // tick walk
   logic [IDX_W-1:0] walk_ff, walk_in, cursor_ff, cursor_in;
   logic [CNT_W-1:0] tcnt_ff, tcnt_in;
   logic [IDX_W-1:0] walk_next;
   logic             tick_last;

   assign walk_next = (walk_ff == IDX_W'(PORTS - 1)) ? '0 : walk_ff + 1'b1;
   assign tick_last = tcnt_ff == CNT_W'(TICK_N - 1);
   assign rd_idx    = is_tick ? walk_ff : sel_idx;

   always_comb begin
      walk_in   = walk_ff;
      tcnt_in   = tcnt_ff;
      cursor_in = cursor_ff;
      if (cmd.tick_load) begin
         walk_in = cursor_ff;
         tcnt_in = '0;
      end else if (cmd.tick_next) begin
         walk_in = walk_next;
         tcnt_in = tcnt_ff + 1'b1;
         if (tick_last) begin
            cursor_in = walk_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff   <= '0;
         tcnt_ff   <= '0;
         cursor_ff <= '0;
      end else begin
         walk_ff   <= walk_in;
         tcnt_ff   <= tcnt_in;
         cursor_ff <= cursor_in;
      end
   end

   // per-port stores
   logic [MODE_W-1:0]  mode_store_ff [PORTS];
   logic [PULSE_W-1:0] compare_store_ff [PORTS];
   logic [TIME_W-1:0]  time_store_ff [PORTS];
   logic [MODE_W-1:0]  mode_rd;
   logic [PULSE_W-1:0] cmp_rd;
   logic [TIME_W-1:0]  time_rd;

   assign mode_rd = mode_store_ff[rd_idx];
   assign cmp_rd  = compare_store_ff[rd_idx];
   assign time_rd = time_store_ff[rd_idx];

   // setpoint product, magnitude kept for the divider
   logic [SP_W-1:0]           sp_aligned;
   logic signed [PULSE_W:0]   span;
   logic signed [PROD_W-1:0]  prod;
   logic [PROD_W-1:0]         prod_abs;
   logic [QUO_W-1:0]          prod_mag_ff;
   logic                      prod_neg_ff;

   always_comb begin
      unique case (op_ff)
         OP_SET10: sp_aligned = {sp_ff[9:0], 6'b0};
         OP_SET12: sp_aligned = {sp_ff[11:0], 4'b0};
         default:  sp_aligned = sp_ff;
      endcase
   end

   assign span     = $signed({1'b0, max_ff}) - $signed({1'b0, min_ff});
   // both operands widen to the full product width before the multiply
   assign prod     = $signed({1'b0, sp_aligned}) * span;
   assign prod_abs = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);

   always_ff @(posedge clock) begin
      if (cmd.load_prod) begin
         prod_mag_ff <= prod_abs[QUO_W-1:0];
         prod_neg_ff <= prod[PROD_W-1];
      end
   end

   logic [SCALE_W-1:0] divisor;
   logic               div_done;
   logic [QUO_W-1:0]   quotient;

   assign divisor = (scale_ff == '0) ? SCALE_W'(1) : scale_ff;

   epc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_mag_ff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   // offset by start, clamp low first, then high
   logic signed [X_W-1:0] q_ext, q_signed, x_val, start_s, max_s;
   logic [PULSE_W-1:0]    clamped;

   assign q_ext    = $signed({2'b0, quotient});
   assign q_signed = prod_neg_ff ? -q_ext : q_ext;
   assign start_s  = $signed({{(X_W - PULSE_W){1'b0}}, start_ff});
   assign max_s    = $signed({{(X_W - PULSE_W){1'b0}}, max_ff});
   assign x_val    = q_signed + start_s;

   always_comb begin
      priority if (x_val < start_s) begin
         clamped = start_ff;
      end else if (x_val > max_s) begin
         clamped = max_ff;
      end else begin
         clamped = x_val[PULSE_W-1:0];
      end
   end

   // store write port
   logic               cm_we, time_we, expired;
   logic [MODE_W-1:0]  wr_mode_in;
   logic [PULSE_W-1:0] wr_cmp_in;

   assign expired = (now_ff - time_rd) > timeout_ff;

   always_comb begin
      cm_we      = 1'b0;
      time_we    = 1'b0;
      wr_mode_in = mode_rd;
      wr_cmp_in  = cmp_rd;
      if (cmd.tick_check) begin
         if (mode_rd != MODE_DISARMED && expired) begin
            cm_we      = 1'b1;
            wr_mode_in = MODE_DISARMED;
            wr_cmp_in  = '0;
         end
      end else if (cmd.write_port) begin
         cm_we = 1'b1;
         unique case (op_ff)
            OP_SET10, OP_SET12, OP_SET16: begin
               time_we   = 1'b1;
               wr_cmp_in = (mode_rd != MODE_DISARMED) ? clamped : '0;
            end
            OP_ARM, OP_STOP: begin
               wr_mode_in = MODE_STOPPED;
               wr_cmp_in  = arm_ff;
            end
            OP_START: begin
               wr_mode_in = MODE_RUNNING;
               wr_cmp_in  = start_ff;
            end
            OP_DISARM: begin
               wr_mode_in = MODE_DISARMED;
               wr_cmp_in  = '0;
            end
            default: cm_we = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PORTS; i++) begin
            mode_store_ff[i]    <= MODE_DISARMED;
            compare_store_ff[i] <= '0;
            time_store_ff[i]    <= '0;
         end
      end else begin
         if (cm_we) begin
            mode_store_ff[rd_idx]    <= wr_mode_in;
            compare_store_ff[rd_idx] <= wr_cmp_in;
         end
         if (time_we) begin
            time_store_ff[rd_idx] <= now_ff;
         end
      end
   end

   // result register
   logic [PORT_W-1:0]  rport_ff;
   logic [PULSE_W-1:0] rcmp_ff;
   logic [MODE_W-1:0]  rmode_ff;
   logic [STAT_W-1:0]  rstat_ff, port_status;
   logic               rreply_ff, rlast_ff;

   always_comb begin
      priority if (op_ff == OP_ACK_NACK) begin
         port_status = ST_DONE;
      end else if (op_ff >= OP_UNSUPPORTED || !port_ok) begin
         port_status = ST_REJECT;
      end else if (op_ff == OP_ARM || op_ff == OP_DISARM || op_ff == OP_START ||
                   op_ff == OP_STOP) begin
         port_status = ST_ACK;
      end else begin
         port_status = ST_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_tick) begin
         rport_ff  <= PORT_W'(walk_ff);
         rcmp_ff   <= cmp_rd;
         rmode_ff  <= mode_rd;
         rstat_ff  <= ST_DONE;
         rreply_ff <= 1'b0;
         rlast_ff  <= tick_last;
      end else if (cmd.emit_port) begin
         rport_ff  <= port_ff;
         rcmp_ff   <= port_ok ? cmp_rd : '0;
         rmode_ff  <= port_ok ? mode_rd : MODE_DISARMED;
         rstat_ff  <= port_status;
         rreply_ff <= port_ok && op_ff == OP_GET_STATE;
         rlast_ff  <= 1'b1;
      end
   end

   assign rsp_out_port      = rport_ff;
   assign rsp_pulse_compare = rcmp_ff;
   assign rsp_port_mode     = rmode_ff;
   assign rsp_status        = rstat_ff;
   assign rsp_reply_valid   = rreply_ff;
   assign rsp_last          = rlast_ff;

   assign stat.op        = op_ff;
   assign stat.port_ok   = port_ok;
   assign stat.div_done  = div_done;
   assign stat.tick_last = tick_last;

   a_disarmed_zero : assert property (@(posedge clock) disable iff (reset)
      mode_rd == MODE_DISARMED |-> cmp_rd == '0)
      else $error("disarmed port drives a nonzero compare");

   a_walk_range : assert property (@(posedge clock) disable iff (reset)
      walk_ff <= IDX_W'(PORTS - 1) && cursor_ff <= IDX_W'(PORTS - 1))
      else $error("tick walk index out of range");

endmodule

// File: hdl/epc_controller.sv
// Command sequencer: decode, scaling sequence, tick walk and result handshake.
module epc_controller
   import epc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  epc_stat_type stat,
   output epc_cmd_type  cmd
);

   typedef enum logic [2:0] {
      IDLE,
      DECODE,
      DIV_GO,
      DIV_WAIT,
      EMIT,
      TICK_CHECK,
      TICK_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      cmd          = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = DECODE;
            end
         end
         DECODE: begin
            priority if (stat.op == OP_TICK) begin
               cmd.tick_load = 1'b1;
               state_in      = TICK_CHECK;
            end else if (stat.op == OP_ACK_NACK || stat.op >= OP_UNSUPPORTED ||
                         !stat.port_ok) begin
               state_in = EMIT;
            end else if (stat.op == OP_SET10 || stat.op == OP_SET12 ||
                         stat.op == OP_SET16) begin
               cmd.load_prod = 1'b1;
               state_in      = DIV_GO;
            end else if (stat.op == OP_GET_STATE) begin
               state_in = EMIT;
            end else begin
               cmd.write_port = 1'b1;
               state_in       = EMIT;
            end
         end
         DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = DIV_WAIT;
         end
         DIV_WAIT: begin
            if (stat.div_done) begin
               cmd.write_port = 1'b1;
               state_in       = EMIT;
            end
         end
         EMIT: begin
            if (out_free) begin
               cmd.emit_port = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = IDLE;
            end
         end
         TICK_CHECK: begin
            cmd.tick_check = 1'b1;
            state_in       = TICK_EMIT;
         end
         TICK_EMIT: begin
            // hold until the result register frees up
            if (out_free) begin
               cmd.emit_tick = 1'b1;
               cmd.tick_next = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = stat.tick_last ? IDLE : TICK_CHECK;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_emit_free : assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_port || cmd.emit_tick) |-> out_free)
      else $error("result word overwritten before it was taken");

   a_div_wait : assert property (@(posedge clock) disable iff (reset)
      stat.div_done |-> state_ff == DIV_WAIT)
      else $error("divider finished outside the wait state");

endmodule

// File: hdl/esc_pwm_command_controller.sv
// Speed-controller command block: top level joining sequencer and datapath.
//
// Commands enter on the req_ channel (valid/ready) one word at a time; each
// produces one result word on the rsp_ channel, except a tick, which produces
// one word per port walked (up to eight), the final one flagged by rsp_last.
// req_ready is high only while no command is in progress; a finished result
// may still wait in the output register while the next command is taken.
// With the receiver ready, arm, disarm, start, stop, get_state, ack_nack,
// rejected and unsupported commands go from decode straight to the result
// register. Setpoints first pass the one-bit-per-cycle 32-bit divider that
// scales the span product. A tick checks and then loads one word per port.
// The next command is taken in the cycle after the last word is loaded.
// When the receiver stalls, the sequencer holds on the full output register;
// no word is lost or repeated. Registers are written through csr_we,
// csr_index and csr_wdata; the user must write them only while the block is
// idle, which the block itself does not enforce. Synchronous reset disarms
// all ports, zeroes compares, times and the tick cursor, and restores the
// register defaults at once; there is no clear pass.
module esc_pwm_command_controller
   import epc_pkg::*;
#(
   parameter int PORTS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [PORT_W-1:0]     req_port,
   input  logic [SP_W-1:0]       req_setpoint,
   input  logic [TIME_W-1:0]     req_now_us,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PORT_W-1:0]     rsp_out_port,
   output logic [PULSE_W-1:0]    rsp_pulse_compare,
   output logic [MODE_W-1:0]     rsp_port_mode,
   output logic [STAT_W-1:0]     rsp_status,
   output logic                  rsp_reply_valid,
   output logic                  rsp_last,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   epc_cmd_type  cmd;
   epc_stat_type stat;

   epc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   epc_datapath #(
      .PORTS (PORTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operation     (req_operation),
      .req_port          (req_port),
      .req_setpoint      (req_setpoint),
      .req_now_us        (req_now_us),
      .rsp_out_port      (rsp_out_port),
      .rsp_pulse_compare (rsp_pulse_compare),
      .rsp_port_mode     (rsp_port_mode),
      .rsp_status        (rsp_status),
      .rsp_reply_valid   (rsp_reply_valid),
      .rsp_last          (rsp_last),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

endmodule
